// ===== rtl/core/bsa_pkg.sv =====
// shared types, constants and helpers for the bitmap slot allocator
package bsa_pkg;

  // slots per bitmap word, and the bits that pick a slot inside a word
  localparam int WORD_W = 8;
  localparam int BIT_W  = 3;

  // widths of the request and result fields
  localparam int OP_W   = 2;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;

  // largest slot count that an 8-bit granted slot can name
  localparam int GRANT_LIMIT = 256;

  // default size of the slot pool
  localparam int SLOTS_DEF = 256;

  // capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_FULL         = 2'd1,
    STAT_RANGE        = 2'd2,
    STAT_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // position of the lowest clear bit of a word, zero when none is clear
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        pos = BIT_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bsa_req_if.sv =====
// request channel: operation and slot index with valid/ready
interface bsa_req_if
  import bsa_pkg::*;
;
  logic             valid;
  logic             ready;
  op_t              operation;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, operation, slot_index, input ready);
  modport sink   (input valid, operation, slot_index, output ready);
endinterface

// ===== rtl/core/bsa_rsp_if.sv =====
// result channel: status, granted slot, query bit and used count with valid/ready
interface bsa_rsp_if
  import bsa_pkg::*;
;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] granted_slot;
  logic             slot_used;
  logic [CNT_W-1:0] used_count;

  modport source (output valid, status, granted_slot, slot_used, used_count, input ready);
  modport sink   (input valid, status, granted_slot, slot_used, used_count, output ready);
endinterface

// ===== rtl/core/bitmap_slot_allocator.sv =====
// bitmap slot allocator top level: request fsm, bitmap ram read-modify-write, result register
// a request transfer starts the ram read; the update fills the result register once it has room
// no new request is taken until the current one finishes the read-then-write of one bitmap word
// a new request is taken while the previous result still waits in the output register
// reset (rst_n low, synchronous): every slot free, count zero, capacity 256, no result pending
// no clearing pass: per-word valid bits make unwritten and cleared words read as free
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  bsa_req_if.sink          in_req,
  bsa_rsp_if.source        out_rsp
);

  // only the first 256 slots can ever be granted, so the store stops there
  localparam int NSLOT  = (SLOTS < GRANT_LIMIT) ? SLOTS : GRANT_LIMIT;
  localparam int NWORDS = (NSLOT + WORD_W - 1) / WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [CNT_W-1:0] NSLOT_C = CNT_W'(NSLOT);

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [NWORDS-1:0]  full_r;    // word summary: every slot of the word used
  logic [NWORDS-1:0]  wvalid_r;  // word written since reset or last clear-all

  // request held across the ram read
  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [AW-1:0]      waddr_r;
  logic               wfound_r;

  // result register
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [IDX_W-1:0]   grant_r, grant_nxt;
  logic               used_r, used_nxt;

  logic               in_xfer;
  logic               exec_fire;
  logic [CNT_W-1:0]   eff_cap;
  logic               find_found;
  logic [AW-1:0]      find_addr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  new_word;
  logic [BIT_W-1:0]   free_bit;
  logic [CNT_W-1:0]   alloc_slot;
  logic               word_bit;
  logic               set_full;
  logic               clr_full;

  // capacity seen by allocation and range checks
  assign eff_cap = (cap_r > NSLOT_C) ? NSLOT_C : cap_r;

  assign in_xfer = in_req.valid && in_req.ready;

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs: take a request when idle, finish once the result register has room
  always_comb begin
    in_req.ready = 1'b0;
    exec_fire    = 1'b0;
    unique case (state_r)
      S_IDLE: in_req.ready = 1'b1;
      S_EXEC: exec_fire    = !out_valid_r || out_rsp.ready;
      default: begin
        in_req.ready = 1'b0;
        exec_fire    = 1'b0;
      end
    endcase
  end

  // first word with a free slot, searched over the summary bits
  bsa_finder #(
    .NWORDS (NWORDS),
    .AW     (AW)
  ) u_finder (
    .full    (full_r),
    .eff_cap (eff_cap),
    .found   (find_found),
    .addr    (find_addr)
  );

  // allocate reads the word the search picked, free and query the named word
  assign ram_raddr = (in_req.operation == OP_ALLOC) ? find_addr
                                                     : in_req.slot_index[BIT_W +: AW];
  assign ram_re    = in_xfer && (in_req.operation != OP_CLEAR);

  bsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_r),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a word not written since the last clear-all reads as all free
  assign word       = wvalid_r[waddr_r] ? ram_rdata : '0;
  assign free_bit   = lowest_zero(word);
  assign alloc_slot = ({{(CNT_W - AW){1'b0}}, waddr_r} << BIT_W) | CNT_W'(free_bit);
  assign word_bit   = word[idx_r[BIT_W-1:0]];

  // modify step: result fields, new word and count
  always_comb begin
    status_nxt = STAT_OK;
    grant_nxt  = '0;
    used_nxt   = 1'b0;
    new_word   = word;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    set_full   = 1'b0;
    clr_full   = 1'b0;
    unique case (op_r)
      OP_ALLOC: begin
        // lower words are all full, so a miss here means nothing free below capacity
        if (!wfound_r || (alloc_slot >= eff_cap)) begin
          status_nxt = STAT_FULL;
        end else begin
          new_word[free_bit] = 1'b1;
          grant_nxt          = alloc_slot[IDX_W-1:0];
          count_nxt          = count_r + 1'b1;
          ram_we             = exec_fire;
          set_full           = &new_word;
        end
      end
      OP_FREE: begin
        if ({1'b0, idx_r} >= eff_cap) begin
          status_nxt = STAT_RANGE;
        end else if (!word_bit) begin
          status_nxt = STAT_ALREADY_FREE;
        end else begin
          new_word[idx_r[BIT_W-1:0]] = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          ram_we   = exec_fire;
          clr_full = 1'b1;
        end
      end
      OP_QUERY: begin
        if ({1'b0, idx_r} >= eff_cap) begin
          status_nxt = STAT_RANGE;
        end else begin
          used_nxt = word_bit;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      full_r      <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (exec_fire) begin
        count_r <= count_nxt;
        if (op_r == OP_CLEAR) begin
          full_r   <= '0;
          wvalid_r <= '0;
        end else begin
          if (ram_we) begin
            wvalid_r[waddr_r] <= 1'b1;
          end
          if (set_full) begin
            full_r[waddr_r] <= 1'b1;
          end else if (clr_full) begin
            full_r[waddr_r] <= 1'b0;
          end
        end
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture at transfer, result capture at the update
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_req.operation;
      idx_r    <= in_req.slot_index;
      waddr_r  <= ram_raddr;
      wfound_r <= find_found;
    end
    if (exec_fire) begin
      status_r <= status_nxt;
      grant_r  <= grant_nxt;
      used_r   <= used_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.granted_slot = grant_r;
  assign out_rsp.slot_used    = used_r;
  assign out_rsp.used_count   = count_r;

endmodule

// ===== rtl/core/bsa_ram.sv =====
// generic single-write, single-read ram with registered read data
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bsa_finder.sv =====
// lowest bitmap word that is not full and starts below the capacity
module bsa_finder
  import bsa_pkg::*;
#(
  parameter int NWORDS = 32,
  parameter int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
  input  logic [NWORDS-1:0] full,
  input  logic [CNT_W-1:0]  eff_cap,
  output logic              found,
  output logic [AW-1:0]     addr
);

  logic [NWORDS-1:0] cand;

  always_comb begin
    for (int w = 0; w < NWORDS; w++) begin
      cand[w] = !full[w] && (CNT_W'(w * WORD_W) < eff_cap);
    end
  end

  // priority encoder, lowest word wins
  always_comb begin
    found = 1'b0;
    addr  = '0;
    for (int w = NWORDS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        found = 1'b1;
        addr  = AW'(w);
      end
    end
  end

endmodule

// ===== rtl/core/bsa_checker.sv =====
// port-level checks for the bitmap slot allocator, bound to the top level
module bsa_checker
  import bsa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input status_t          out_status,
  input logic [IDX_W-1:0] out_granted_slot,
  input logic             out_slot_used,
  input logic [CNT_W-1:0] out_used_count
);

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_granted_slot) && $stable(out_slot_used) && $stable(out_used_count))
    else $error("result changed while stalled");

  // a full report never names a slot
  a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_granted_slot == '0))
    else $error("grant given with full status");

  // the query bit is only set by a successful query
  a_used_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> !out_slot_used)
    else $error("slot_used set on a failed request");

  // the count never passes the largest pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used_count <= CNT_W'(GRANT_LIMIT)))
    else $error("used count beyond pool size");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_granted_slot (out_rsp.granted_slot),
  .out_slot_used    (out_rsp.slot_used),
  .out_used_count   (out_rsp.used_count)
);
